### rtl/core/gsa_pkg.sv
// gsa_pkg: shared types and constants for the generalized suffix automaton builder
// no dependencies
`timescale 1ns / 1ps
package gsa_pkg;

   localparam int unsigned ROOT_STATE = 1;

   typedef enum logic [15:0] {
      ST_IDLE    = 16'b0000_0000_0000_0001,
      ST_RDLAST  = 16'b0000_0000_0000_0010,
      ST_CHKLAST = 16'b0000_0000_0000_0100,
      ST_RDQ     = 16'b0000_0000_0000_1000,
      ST_CHKQ    = 16'b0000_0000_0001_0000,
      ST_WALKRD  = 16'b0000_0000_0010_0000,
      ST_WALKCHK = 16'b0000_0000_0100_0000,
      ST_RDQ2    = 16'b0000_0000_1000_0000,
      ST_CHKQ2   = 16'b0000_0001_0000_0000,
      ST_CPRD    = 16'b0000_0010_0000_0000,
      ST_CPWR    = 16'b0000_0100_0000_0000,
      ST_SPLRD   = 16'b0000_1000_0000_0000,
      ST_SPLCHK  = 16'b0001_0000_0000_0000,
      ST_FINRD   = 16'b0010_0000_0000_0000,
      ST_RESP    = 16'b0100_0000_0000_0000,
      ST_CLEAR   = 16'b1000_0000_0000_0000
   } fsm_type;

endpackage

### rtl/core/gsa_ram.sv
// gsa_ram: generic single port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
module gsa_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### rtl/core/generalized_suffix_automaton_builder_core.sv
// generalized_suffix_automaton_builder_core: online generalized suffix automaton builder
// depends on gsa_pkg and gsa_ram
`timescale 1ns / 1ps
// one letter per start beat; busy stays high from the accepting edge up to the cycle of the
// single rsp_valid beat, and falls in that cycle, so the next letter can be taken at the
// edge that ends the beat. the result takes longer as the letter needs more suffix-link
// steps or redirect steps, ends a walk on an existing transition, or needs a clone, which
// copies every transition entry of q. an ignored or dropped letter answers without
// changing the stores. after reset the stores are swept clear, one transition entry a
// cycle, with busy high.
// the receiver cannot stall: each result is on the rsp_ ports for exactly one cycle.
module generalized_suffix_automaton_builder_core
   import gsa_pkg::*;
#(
   parameter int unsigned STATE_COUNT   = 1024,
   parameter int unsigned ALPHABET_SIZE = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_letter_index,
   input  logic        req_new_string,
   output logic        rsp_valid,
   output logic [9:0]  rsp_end_state,
   output logic [9:0]  rsp_end_length,
   output logic [10:0] rsp_states_used,
   output logic        rsp_overflow
);
   localparam int unsigned SW = $clog2(STATE_COUNT);
   localparam int unsigned CW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int unsigned TDEPTH = STATE_COUNT * ALPHABET_SIZE;
   localparam int unsigned TW = $clog2(TDEPTH);
   localparam int unsigned NW = SW + 1;
   localparam int unsigned LW = SW + 1;

   fsm_type fsm_ff, fsm_in;

   // registers
   logic [SW-1:0] cur_ff, cur_in;        // current_state
   logic [NW-1:0] cnt_ff, cnt_in;        // allocated_count
   logic [SW-1:0] last_ff, last_in;
   logic [SW-1:0] p_ff, p_in;
   logic [SW-1:0] q_ff, q_in;
   logic [SW-1:0] nw_ff, nw_in;          // new state (cur)
   logic [SW-1:0] cl_ff, cl_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic [CW-1:0] c_ff, c_in;
   logic [CW-1:0] k_ff, k_in;            // copy index, also the clear sweep index
   logic [SW-1:0] clr_ff, clr_in;
   logic [SW:0]   steps_ff, steps_in;
   logic          walk_new_ff, walk_new_in; // split from new-state path
   logic          ovf_ff, ovf_in;
   logic          busy_ff, busy_in;
   logic          rv_ff, rv_in;

   // memories: length+link combined node word, and transitions
   logic            nd_we;
   logic [SW-1:0]   nd_addr;
   logic [2*LW-1:0] nd_wd, nd_rd;
   logic            tr_we;
   logic [TW-1:0]   tr_addr;
   logic [SW-1:0]   tr_wd, tr_rd;
   logic [LW-1:0]   rd_len;
   logic [SW-1:0]   rd_link;

   assign rd_len  = nd_rd[2*LW-1:LW];
   assign rd_link = nd_rd[SW-1:0];

   gsa_ram #(.WIDTH(2*LW), .DEPTH(STATE_COUNT)) u_node (
      .clock(clock), .wr_en(nd_we), .addr(nd_addr), .wr_data(nd_wd), .rd_data(nd_rd));
   gsa_ram #(.WIDTH(SW), .DEPTH(TDEPTH)) u_tr (
      .clock(clock), .wr_en(tr_we), .addr(tr_addr), .wr_data(tr_wd), .rd_data(tr_rd));

   function automatic logic [TW-1:0] taddr(input logic [SW-1:0] s, input logic [CW-1:0] c);
      logic [TW+SW-1:0] w;
      w = TW'(s) * TW'(ALPHABET_SIZE) + TW'(c);
      return w[TW-1:0];
   endfunction

   function automatic logic [2*LW-1:0] node(input logic [LW-1:0] l, input logic [SW-1:0] k);
      return {l, LW'(k)};
   endfunction

   // fields of the node word are LW wide; link uses low SW bits
   logic [LW-1:0] last_len_ff, last_len_in;
   logic [LW-1:0] reply_len_ff, reply_len_in;

   always_comb begin
      fsm_in = fsm_ff; cur_in = cur_ff; cnt_in = cnt_ff; last_in = last_ff; p_in = p_ff;
      q_in = q_ff; nw_in = nw_ff; cl_in = cl_ff; plen_in = plen_ff; c_in = c_ff; k_in = k_ff;
      clr_in = clr_ff; steps_in = steps_ff; walk_new_in = walk_new_ff; ovf_in = ovf_ff;
      busy_in = busy_ff; rv_in = 1'b0; last_len_in = last_len_ff; reply_len_in = reply_len_ff;
      nd_we = 1'b0; nd_addr = cur_ff; nd_wd = '0;
      tr_we = 1'b0; tr_addr = taddr(last_ff, c_ff); tr_wd = '0;
      unique case (fsm_ff)
         ST_CLEAR: begin
            nd_we = 1'b1; nd_addr = clr_ff; nd_wd = '0;
            tr_we = 1'b1; tr_addr = taddr(clr_ff, k_ff); tr_wd = '0;
            if (k_ff == CW'(ALPHABET_SIZE - 1)) begin
               k_in = '0;
               clr_in = clr_ff + 1'b1;
               if (clr_ff == SW'(STATE_COUNT - 1)) begin
                  fsm_in = ST_IDLE; busy_in = 1'b0;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               busy_in = 1'b1;
               ovf_in = 1'b0;
               if (32'(req_letter_index) >= ALPHABET_SIZE) begin
                  fsm_in = ST_FINRD;
               end else if (cnt_ff > NW'(STATE_COUNT - 2)) begin
                  ovf_in = 1'b1; fsm_in = ST_FINRD;
               end else begin
                  c_in = CW'(req_letter_index);
                  last_in = req_new_string ? SW'(ROOT_STATE) : cur_ff;
                  fsm_in = ST_RDLAST;
               end
            end
         end
         ST_RDLAST: begin
            nd_addr = last_ff; tr_addr = taddr(last_ff, c_ff);
            fsm_in = ST_CHKLAST;
         end
         ST_CHKLAST: begin
            last_len_in = rd_len;
            if (tr_rd != '0) begin
               q_in = tr_rd; p_in = last_ff; plen_in = rd_len; walk_new_in = 1'b0;
               fsm_in = ST_RDQ;
            end else begin
               nw_in = cnt_ff[SW-1:0]; cnt_in = cnt_ff + 1'b1;
               nd_we = 1'b1; nd_addr = cnt_ff[SW-1:0];
               nd_wd = node(rd_len + 1'b1, '0);
               p_in = last_ff; steps_in = '0;
               fsm_in = ST_WALKRD;
            end
         end
         ST_RDQ: begin
            nd_addr = q_ff; fsm_in = ST_CHKQ;
         end
         ST_CHKQ: begin
            if (plen_ff + 1'b1 == rd_len) begin
               cur_in = q_ff; fsm_in = ST_FINRD;
            end else begin
               fsm_in = ST_CPRD; k_in = '0;
               cl_in = cnt_ff[SW-1:0]; cnt_in = cnt_ff + 1'b1;
               // clone node word: length, link of q
               nd_we = 1'b1; nd_addr = cnt_ff[SW-1:0];
               nd_wd = node(plen_ff + 1'b1, rd_link);
            end
         end
         ST_WALKRD: begin
            nd_addr = p_ff; tr_addr = taddr(p_ff, c_ff);
            fsm_in = ST_WALKCHK;
         end
         ST_WALKCHK: begin
            if (tr_rd == '0 && steps_ff < (SW+1)'(STATE_COUNT)) begin
               tr_we = 1'b1; tr_addr = taddr(p_ff, c_ff); tr_wd = nw_ff;
               p_in = rd_link; steps_in = steps_ff + 1'b1;
               if (rd_link == '0) begin
                  nd_we = 1'b1; nd_addr = nw_ff;
                  nd_wd = node(last_len_ff + 1'b1, SW'(ROOT_STATE));
                  cur_in = nw_ff; fsm_in = ST_FINRD;
               end else begin
                  fsm_in = ST_WALKRD;
               end
            end else begin
               q_in = tr_rd; plen_in = rd_len; walk_new_in = 1'b1;
               fsm_in = ST_RDQ2;
            end
         end
         ST_RDQ2: begin
            nd_addr = q_ff; fsm_in = ST_CHKQ2;
         end
         ST_CHKQ2: begin
            if (plen_ff + 1'b1 == rd_len) begin
               nd_we = 1'b1; nd_addr = nw_ff; nd_wd = node(last_len_ff + 1'b1, q_ff);
               cur_in = nw_ff; fsm_in = ST_FINRD;
            end else begin
               fsm_in = ST_CPRD; k_in = '0;
               cl_in = cnt_ff[SW-1:0]; cnt_in = cnt_ff + 1'b1;
               nd_we = 1'b1; nd_addr = cnt_ff[SW-1:0];
               nd_wd = node(plen_ff + 1'b1, rd_link);
            end
         end
         ST_CPRD: begin
            tr_addr = taddr(q_ff, k_ff); fsm_in = ST_CPWR;
         end
         ST_CPWR: begin
            tr_we = 1'b1; tr_addr = taddr(cl_ff, k_ff); tr_wd = tr_rd;
            if (k_ff == CW'(ALPHABET_SIZE - 1)) begin
               steps_in = '0; fsm_in = ST_SPLRD;
               // link of q now points at the clone
               nd_we = 1'b1; nd_addr = q_ff;
               nd_wd = node(reply_len_ff, cl_ff);
            end else begin
               k_in = k_ff + 1'b1; fsm_in = ST_CPRD;
            end
            // the relink write above uses the length of q captured in ST_CHKQ or ST_CHKQ2
         end
         ST_SPLRD: begin
            nd_addr = p_ff; tr_addr = taddr(p_ff, c_ff); fsm_in = ST_SPLCHK;
         end
         ST_SPLCHK: begin
            if (p_ff != '0 && tr_rd == q_ff && steps_ff < (SW+1)'(STATE_COUNT)) begin
               tr_we = 1'b1; tr_addr = taddr(p_ff, c_ff); tr_wd = cl_ff;
               p_in = rd_link; steps_in = steps_ff + 1'b1; fsm_in = ST_SPLRD;
            end else if (walk_new_ff) begin
               nd_we = 1'b1; nd_addr = nw_ff; nd_wd = node(last_len_ff + 1'b1, cl_ff);
               cur_in = nw_ff; fsm_in = ST_FINRD;
            end else begin
               cur_in = cl_ff; fsm_in = ST_FINRD;
            end
         end
         ST_FINRD: begin
            nd_addr = cur_ff; fsm_in = ST_RESP;
         end
         ST_RESP: begin
            rv_in = 1'b1; reply_len_in = rd_len; busy_in = 1'b0; fsm_in = ST_IDLE;
         end
         default: fsm_in = ST_IDLE;
      endcase
      // keep q length for the relink: captured while clone header written
      if (fsm_ff == ST_CHKQ || fsm_ff == ST_CHKQ2) begin
         reply_len_in = rd_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= ST_CLEAR; cur_ff <= SW'(ROOT_STATE); cnt_ff <= NW'(2);
         clr_ff <= '0; k_ff <= '0; busy_ff <= 1'b1; rv_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in; cur_ff <= cur_in; cnt_ff <= cnt_in;
         clr_ff <= clr_in; k_ff <= k_in; busy_ff <= busy_in; rv_ff <= rv_in;
      end
      last_ff <= last_in; p_ff <= p_in; q_ff <= q_in; nw_ff <= nw_in; cl_ff <= cl_in;
      plen_ff <= plen_in; c_ff <= c_in; steps_ff <= steps_in; walk_new_ff <= walk_new_in;
      ovf_ff <= ovf_in; last_len_ff <= last_len_in; reply_len_ff <= reply_len_in;
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rv_ff;
   assign rsp_end_state   = 10'(cur_ff);
   assign rsp_end_length  = 10'(reply_len_ff);
   assign rsp_states_used = 11'(cnt_ff);
   assign rsp_overflow    = ovf_ff;

   // a result beat is only shown while the state machine is idle
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fsm_ff == ST_IDLE) else $error("result beat outside idle");
   // allocation never passes the store
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(STATE_COUNT)) else $error("allocation count past store size");
   // a result follows only from busy
   a_resp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");
endmodule

### test/tb_generalized_suffix_automaton_builder_core.sv
// testbench for generalized_suffix_automaton_builder_core: random and directed letter streams
// checked beat by beat against an in-bench automaton predictor; depends on gsa_pkg and the rtl
`timescale 1ns / 1ps
module tb_generalized_suffix_automaton_builder_core;
   import gsa_pkg::*;

   localparam int unsigned NSTATES  = 1024;
   localparam int unsigned NLETTERS = 26;
   // the watchdog must outlast the sweep after reset, which clears NSTATES*NLETTERS entries
   localparam int unsigned WATCHDOG = 120000;

   typedef struct {
      logic [4:0] letter;
      logic       restart;
   } letter_beat_type;

   typedef struct {
      logic [9:0]  end_state;
      logic [9:0]  end_length;
      logic [10:0] states_used;
      logic        overflow;
   } sam_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [4:0]  req_letter_index;
   logic        req_new_string;
   logic        rsp_valid;
   logic [9:0]  rsp_end_state;
   logic [9:0]  rsp_end_length;
   logic [10:0] rsp_states_used;
   logic        rsp_overflow;

   generalized_suffix_automaton_builder_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_letter_index (req_letter_index),
      .req_new_string   (req_new_string),
      .rsp_valid        (rsp_valid),
      .rsp_end_state    (rsp_end_state),
      .rsp_end_length   (rsp_end_length),
      .rsp_states_used  (rsp_states_used),
      .rsp_overflow     (rsp_overflow)
   );

   // predicted automaton
   int unsigned sam_len  [NSTATES];
   int unsigned sam_link [NSTATES];
   int unsigned sam_next [NSTATES*NLETTERS];
   int unsigned sam_cur;
   int unsigned sam_alloc;

   letter_beat_type pending_letters[$];
   sam_result_type  awaited_results[$];

   int unsigned errors;
   int unsigned letters_sent;
   int unsigned results_seen;
   int unsigned overflows_seen;
   int unsigned idle_cycles;
   bit          took;
   bit          no_gaps;
   int unsigned gap_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned node(int unsigned s);
      return (s < NSTATES) ? s : 0;
   endfunction

   function automatic int unsigned take_node();
      int unsigned n;
      n = sam_alloc;
      sam_alloc++;
      return node(n);
   endfunction

   // clone q (target of p on c) and redirect the chain of p's links onto the clone
   function automatic int unsigned split_node(int unsigned p, int unsigned q, int unsigned c);
      int unsigned cl;
      int unsigned steps;
      cl = take_node();
      steps = 0;
      sam_len[cl] = sam_len[node(p)] + 1;
      for (int k = 0; k < NLETTERS; k++)
         sam_next[cl*NLETTERS + k] = sam_next[node(q)*NLETTERS + k];
      sam_link[cl] = sam_link[node(q)];
      while (p != 0 && sam_next[node(p)*NLETTERS + c] == q && steps < NSTATES) begin
         sam_next[node(p)*NLETTERS + c] = cl;
         p = sam_link[node(p)];
         steps++;
      end
      sam_link[node(q)] = cl;
      return cl;
   endfunction

   function automatic sam_result_type grow_automaton(logic [4:0] letter, logic restart);
      sam_result_type r;
      int unsigned c, last, q, cur, p, steps;
      r.overflow = 1'b0;
      if (letter >= NLETTERS) begin
         // ignored letter, nothing changes
      end else if (sam_alloc > NSTATES || NSTATES - sam_alloc < 2) begin
         r.overflow = 1'b1;
      end else begin
         c = letter;
         if (restart) sam_cur = ROOT_STATE;
         last = node(sam_cur);
         q = sam_next[last*NLETTERS + c];
         if (q != 0) begin
            if (sam_len[last] + 1 == sam_len[node(q)]) sam_cur = q;
            else sam_cur = split_node(last, q, c);
         end else begin
            cur = take_node();
            p = last;
            steps = 0;
            sam_len[cur] = sam_len[last] + 1;
            while (p != 0 && sam_next[node(p)*NLETTERS + c] == 0 && steps < NSTATES) begin
               sam_next[node(p)*NLETTERS + c] = cur;
               p = sam_link[node(p)];
               steps++;
            end
            if (p == 0) begin
               sam_link[cur] = ROOT_STATE;
            end else begin
               q = sam_next[node(p)*NLETTERS + c];
               if (sam_len[node(p)] + 1 == sam_len[node(q)]) sam_link[cur] = q;
               else sam_link[cur] = split_node(p, q, c);
            end
            sam_cur = cur;
         end
      end
      r.end_state   = sam_cur[9:0];
      r.end_length  = sam_len[node(sam_cur)][9:0];
      r.states_used = sam_alloc[10:0];
      return r;
   endfunction

   // monitor: accepted beats feed the predictor, result beats are checked in order
   always @(posedge clock) begin
      sam_result_type exp_r;
      took <= start && !busy && !reset;
      if (!reset) begin
         if (start && !busy) begin
            awaited_results.push_back(grow_automaton(req_letter_index, req_new_string));
            letters_sent++;
         end
         if (rsp_valid) begin
            results_seen++;
            if (rsp_overflow) overflows_seen++;
            if (awaited_results.size() == 0) begin
               $error("result beat with nothing awaited: state %0d", rsp_end_state);
               errors++;
            end else begin
               exp_r = awaited_results.pop_front();
               if (rsp_end_state !== exp_r.end_state) begin
                  $error("end_state expected %0d got %0d", exp_r.end_state, rsp_end_state);
                  errors++;
               end
               if (rsp_end_length !== exp_r.end_length) begin
                  $error("end_length expected %0d got %0d", exp_r.end_length, rsp_end_length);
                  errors++;
               end
               if (rsp_states_used !== exp_r.states_used) begin
                  $error("states_used expected %0d got %0d", exp_r.states_used,
                         rsp_states_used);
                  errors++;
               end
               if (rsp_overflow !== exp_r.overflow) begin
                  $error("overflow expected %0d got %0d", exp_r.overflow, rsp_overflow);
                  errors++;
               end
            end
         end
         // watchdog on cycles with no beat in either direction
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // driver: at most one nonblocking write to start per falling edge
   always @(negedge clock) begin
      letter_beat_type b;
      logic            nxt;
      int unsigned     r;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         nxt = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_letters.size() > 0) begin
            b = pending_letters.pop_front();
            req_letter_index <= b.letter;
            req_new_string   <= b.restart;
            nxt = 1'b1;
            r = $urandom_range(0, 99);
            if (no_gaps || r < 50) gap_left = 0;
            else if (r < 92) gap_left = $urandom_range(1, 3);
            else gap_left = $urandom_range(10, 40);
         end
         start <= nxt;
      end
   end

   task automatic queue_letter(int unsigned letter, bit restart);
      letter_beat_type b;
      b.letter  = letter[4:0];
      b.restart = restart;
      pending_letters.push_back(b);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (!(pending_letters.size() == 0 && !start && awaited_results.size() == 0));
   endtask

   initial begin
      int unsigned words[10][$];
      int unsigned queued;
      int unsigned w, n;
      int unsigned chunk;

      errors = 0; letters_sent = 0; results_seen = 0; overflows_seen = 0;
      idle_cycles = 0; gap_left = 0; no_gaps = 0; took = 0;
      sam_len = '{default: 0}; sam_link = '{default: 0}; sam_next = '{default: 0};
      sam_cur = ROOT_STATE; sam_alloc = 2;
      reset = 1'b1; start = 1'b0; req_letter_index = '0; req_new_string = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: letter extremes, ignored letters, repeats that force clones
      queue_letter(0, 1);  queue_letter(25, 0); queue_letter(25, 0); queue_letter(0, 0);
      queue_letter(31, 1); queue_letter(26, 0); queue_letter(0, 1);  queue_letter(25, 0);
      queue_letter(1, 1);  queue_letter(0, 0);  queue_letter(1, 0);  queue_letter(0, 0);
      queue_letter(1, 0);  queue_letter(0, 1);  queue_letter(0, 0);  queue_letter(1, 0);
      queue_letter(0, 0);  queue_letter(0, 0);  queue_letter(1, 1);  queue_letter(1, 0);
      queue_letter(16, 0); queue_letter(15, 1); queue_letter(30, 0);
      wait_drained();

      // a small dictionary over a few letters, so strings share long prefixes
      for (int i = 0; i < 10; i++) begin
         n = $urandom_range(1, 10);
         for (int j = 0; j < n; j++) words[i].push_back($urandom_range(0, 3));
      end

      queued = 0;
      while (queued < 1100) begin
         if ($urandom_range(0, 19) == 0) begin
            // noise: out-of-range letter
            queue_letter($urandom_range(26, 31), $urandom_range(0, 1));
         end else begin
            w = $urandom_range(0, 9);
            for (int j = 0; j < words[w].size(); j++) begin
               if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 25);
               else n = words[w][j];
               queue_letter(n, j == 0 && $urandom_range(0, 9) != 0);
               queued++;
            end
         end
         if (queued > 550 && queued < 600) no_gaps = 1;
         else no_gaps = 0;
      end
      no_gaps = 0;
      // pause until every awaited result is back
      wait_drained();

      // flood with fresh letters until the state store runs out, then a little more
      chunk = 0;
      while (chunk < 30 && (overflows_seen < 20 || chunk < 14)) begin
         for (int j = 0; j < 50; j++) begin
            n = $urandom_range(0, 39);
            queue_letter(n < 26 ? n : $urandom_range(0, 31), $urandom_range(0, 9) == 0);
         end
         wait_drained();
         chunk++;
      end

      repeat (60) @(posedge clock);
      $display("letters sent %0d, results checked %0d, overflow results %0d",
               letters_sent, results_seen, overflows_seen);
      $display("final states allocated %0d of %0d", sam_alloc, NSTATES);
      if (errors == 0 && awaited_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
